@@ hdl/lhco_pkg.sv @@
package lhco_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_CURSOR_CONTROL = 3'd0;
  localparam logic [2:0] REG_FULL_SIZE      = 3'd1;
  localparam logic [2:0] REG_POS_X          = 3'd2;
  localparam logic [2:0] REG_POS_Y          = 3'd3;
  localparam logic [2:0] REG_CLIP_XY        = 3'd4;
  localparam logic [2:0] REG_PALETTE_ZERO   = 3'd5;
  localparam logic [2:0] REG_PALETTE_ONE    = 3'd6;
  localparam logic [2:0] REG_IDLE_COLORS    = 3'd7;

  // Input beat kinds
  localparam logic MODE_IMAGE_WRITE = 1'b0;
  localparam logic MODE_PIXEL       = 1'b1;

  // Cursor pixel codes
  localparam logic [1:0] CODE_PAL0   = 2'd0;
  localparam logic [1:0] CODE_PAL1   = 2'd1;
  localparam logic [1:0] CODE_CLEAR  = 2'd2;
  localparam logic [1:0] CODE_INVERT = 2'd3;

  // Color constants
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [31:0] IDLE_MASK    = 32'hFF808080;
  localparam logic [23:0] INV_FULL     = 24'hFFFFFF;
  localparam logic [23:0] INV_IDLE     = 24'h808080;

  localparam int IMAGE_BYTES = 1024;
  localparam int IMAGE_AW    = 10;

  typedef struct packed {
    logic [5:0]  cursor_control;
    logic        full_size;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [11:0] clip_xy;
    logic [23:0] palette_zero;
    logic [23:0] palette_one;
    logic        idle_colors;
  } cfg_t;

  typedef struct packed {
    logic                mode;
    logic [IMAGE_AW-1:0] image_addr;
    logic [7:0]          image_byte;
    logic [8:0]          pixel_x;
    logic [7:0]          pixel_y;
    logic [31:0]         background;
  } item_t;

  typedef struct packed {
    logic        is_pixel;
    logic        hit;
    logic [1:0]  pix_sel;
    logic [31:0] background;
  } locate_t;

endpackage

@@ hdl/lhco_ram.sv @@
module lhco_ram import lhco_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/lhco_locate.sv @@
module lhco_locate import lhco_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  cfg_t                cfg,
  input  logic                item_valid,
  input  item_t               item,
  output logic [IMAGE_AW-1:0] rd_addr,
  output logic                loc_valid,
  output locate_t             loc
);

  localparam logic [12:0] SW = 13'(SCREEN_WIDTH);
  localparam logic [12:0] SH = 13'(SCREEN_HEIGHT);

  logic [6:0]  dim;
  logic [5:0]  clip_x;
  logic [5:0]  clip_y;
  logic [11:0] cx;
  logic [11:0] cy;
  logic        cursor_ok;
  logic        pixel_ok;
  logic        in_box;
  locate_t     loc_nxt;
  logic        loc_valid_r;
  locate_t     loc_r;

  // Cursor-relative coordinate and visibility
  always_comb begin
    dim    = cfg.full_size ? 7'd64 : 7'd32;
    clip_x = cfg.clip_xy[5:0];
    clip_y = cfg.clip_xy[11:6];
    cx     = {3'b0, item.pixel_x} - cfg.pos_x;
    cy     = {4'b0, item.pixel_y} - cfg.pos_y;
    cursor_ok = cfg.cursor_control[0]
             && ({1'b0, clip_x} < dim) && ({1'b0, clip_y} < dim)
             && ({1'b0, cfg.pos_x} < SW) && ({1'b0, cfg.pos_y} < SH);
    pixel_ok  = ({4'b0, item.pixel_x} < SW) && ({5'b0, item.pixel_y} < SH)
             && ({3'b0, item.pixel_x} >= cfg.pos_x)
             && ({4'b0, item.pixel_y} >= cfg.pos_y);
    in_box    = (cx >= {6'b0, clip_x}) && (cy >= {6'b0, clip_y})
             && (cx < {5'b0, dim}) && (cy < {5'b0, dim});
  end

  // Image byte address: 64x64 uses all bytes, 32x32 picks a 256-byte image
  always_comb begin
    if (cfg.full_size) begin
      rd_addr = {cy[5:0], cx[5:2]};
    end else begin
      rd_addr = {cfg.cursor_control[5:4], cy[4:0], cx[4:2]};
    end
    loc_nxt.is_pixel   = (item.mode == MODE_PIXEL);
    loc_nxt.hit        = cursor_ok && pixel_ok && in_box;
    loc_nxt.pix_sel    = cx[1:0];
    loc_nxt.background = item.background;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_valid_r <= 1'b0;
    end else if (advance) begin
      loc_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      loc_r <= loc_nxt;
    end
  end

  assign loc_valid = loc_valid_r;
  assign loc       = loc_r;

endmodule

@@ hdl/lhco_blend.sv @@
module lhco_blend import lhco_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  cfg_t        cfg,
  input  logic        loc_valid,
  input  locate_t     loc,
  input  logic [7:0]  image_byte,
  output logic        res_valid,
  output logic [31:0] res_color,
  output logic        res_covered
);

  logic [1:0]  code;
  logic [31:0] pal0;
  logic [31:0] pal1;
  logic [23:0] inv;
  logic [31:0] color_nxt;
  logic        covered_nxt;
  logic        res_valid_r;
  logic [31:0] res_color_r;
  logic        res_covered_r;

  // Pick the 2-bit code, first pixel in the top bits
  always_comb begin
    unique case (loc.pix_sel)
      2'd0:    code = image_byte[7:6];
      2'd1:    code = image_byte[5:4];
      2'd2:    code = image_byte[3:2];
      default: code = image_byte[1:0];
    endcase
  end

  // Palettes and inversion mask, reduced in idle mode
  always_comb begin
    pal0 = {ALPHA_OPAQUE, cfg.palette_zero};
    pal1 = {ALPHA_OPAQUE, cfg.palette_one};
    inv  = INV_FULL;
    if (cfg.idle_colors) begin
      pal0 = pal0 & IDLE_MASK;
      pal1 = pal1 & IDLE_MASK;
      inv  = INV_IDLE;
    end
  end

  // Composite
  always_comb begin
    color_nxt   = loc.background;
    covered_nxt = 1'b0;
    if (loc.hit) begin
      unique case (code)
        CODE_PAL0: begin
          color_nxt   = pal0;
          covered_nxt = 1'b1;
        end
        CODE_PAL1: begin
          color_nxt   = pal1;
          covered_nxt = 1'b1;
        end
        CODE_INVERT: begin
          color_nxt   = loc.background ^ {8'h00, inv};
          covered_nxt = 1'b1;
        end
        default: begin
          color_nxt   = loc.background;
          covered_nxt = 1'b0;
        end
      endcase
    end
  end

  // Output register; image writes leave a bubble
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= loc_valid && loc.is_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_color_r   <= color_nxt;
      res_covered_r <= covered_nxt;
    end
  end

  assign res_valid   = res_valid_r;
  assign res_color   = res_color_r;
  assign res_covered = res_covered_r;

endmodule

@@ hdl/lcd_hardware_cursor_overlay_core.sv @@
// A pixel beat passes the input, locate and blend output registers before out_tvalid rises.
// Throughput: one beat per cycle while out_tready is high; a waiting result holds the pipe.
// Image-write beats go to the RAM from the input stage register and produce no output beat.
// Reset (rst_n low, synchronous) clears the configuration registers and pipe valids, then
// a pass over all 1024 bytes zeroes the cursor image RAM, one byte a cycle, with
// in_tready held low; configuration writes are taken during that pass.
module lcd_hardware_cursor_overlay_core import lhco_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // image_addr[9:0], image_byte[17:10], pixel_x[26:18],
                                 // pixel_y[34:27], background[66:35], zero[71:67]
  input  logic        in_tuser,  // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata  // color[31:0], covered[32], zero[39:33]
);

  cfg_t                cfg_r;
  logic                clearing_r;
  logic [IMAGE_AW-1:0] clr_addr_r;
  logic                advance;
  logic                s1_valid_r;
  item_t               s1_r;
  logic [IMAGE_AW-1:0] rd_addr;
  logic                loc_valid;
  locate_t             loc;
  logic [7:0]          ram_rd_data;
  logic                ram_we;
  logic [IMAGE_AW-1:0] ram_wr_addr;
  logic [7:0]          ram_wr_data;
  logic                res_valid;
  logic [31:0]         res_color;
  logic                res_covered;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CURSOR_CONTROL: cfg_r.cursor_control <= cfg_wdata[5:0];
        REG_FULL_SIZE:      cfg_r.full_size      <= cfg_wdata[0];
        REG_POS_X:          cfg_r.pos_x          <= cfg_wdata[11:0];
        REG_POS_Y:          cfg_r.pos_y          <= cfg_wdata[11:0];
        REG_CLIP_XY:        cfg_r.clip_xy        <= cfg_wdata[11:0];
        REG_PALETTE_ZERO:   cfg_r.palette_zero   <= cfg_wdata;
        REG_PALETTE_ONE:    cfg_r.palette_one    <= cfg_wdata;
        REG_IDLE_COLORS:    cfg_r.idle_colors    <= cfg_wdata[0];
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  // Clearing pass over the image RAM after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == '1) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Whole pipe moves when the output register is free
  assign advance   = !out_tvalid || out_tready;
  assign in_tready = advance && !clearing_r;

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r.mode       <= in_tuser;
      s1_r.image_addr <= in_tdata[9:0];
      s1_r.image_byte <= in_tdata[17:10];
      s1_r.pixel_x    <= in_tdata[26:18];
      s1_r.pixel_y    <= in_tdata[34:27];
      s1_r.background <= in_tdata[66:35];
    end
  end

  // Locate stage: hit test and RAM address
  lhco_locate #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_locate (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .cfg        (cfg_r),
    .item_valid (s1_valid_r),
    .item       (s1_r),
    .rd_addr    (rd_addr),
    .loc_valid  (loc_valid),
    .loc        (loc)
  );

  // Image writes enter the RAM in stream order with the pixel reads
  always_comb begin
    if (clearing_r) begin
      ram_we      = 1'b1;
      ram_wr_addr = clr_addr_r;
      ram_wr_data = '0;
    end else begin
      ram_we      = advance && s1_valid_r && (s1_r.mode == MODE_IMAGE_WRITE);
      ram_wr_addr = s1_r.image_addr;
      ram_wr_data = s1_r.image_byte;
    end
  end

  lhco_ram #(
    .WIDTH (8),
    .DEPTH (IMAGE_BYTES)
  ) u_image_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (advance),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // Blend stage and output register
  lhco_blend u_blend (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .cfg         (cfg_r),
    .loc_valid   (loc_valid),
    .loc         (loc),
    .image_byte  (ram_rd_data),
    .res_valid   (res_valid),
    .res_color   (res_color),
    .res_covered (res_covered)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {7'b0, res_covered, res_color};

endmodule
